// ----- rtl/core/ymr_pkg.sv -----
// shared types and constants for the ymodem batch receiver
`default_nettype none
package ymr_pkg;
  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [1:0] K_TX   = 2'd0;
  localparam logic [1:0] K_DATA = 2'd1;
  localparam logic [1:0] K_VERD = 2'd2;
  localparam logic [1:0] K_END  = 2'd3;

  localparam logic [2:0] V_KEPT  = 3'd0;
  localparam logic [2:0] V_DUP   = 3'd1;
  localparam logic [2:0] V_NAME  = 3'd2;
  localparam logic [2:0] V_REJ   = 3'd3;
  localparam logic [2:0] V_EMPTY = 3'd4;

  localparam logic [1:0] ES_DONE    = 2'd0;
  localparam logic [1:0] ES_CANCEL  = 2'd1;
  localparam logic [1:0] ES_SYNC    = 2'd2;
  localparam logic [1:0] ES_RETRANS = 2'd3;

  localparam logic [2:0] REG_HDR   = 3'd0;
  localparam logic [2:0] REG_BYTE  = 3'd1;
  localparam logic [2:0] REG_QUIET = 3'd2;
  localparam logic [2:0] REG_RETR  = 3'd3;
  localparam logic [2:0] REG_SYNC  = 3'd4;

  localparam logic [1:0] PS_NONE = 2'd0;
  localparam logic [1:0] PS_C    = 2'd1;
  localparam logic [1:0] PS_NAK  = 2'd2;

  localparam logic [10:0] SHORT_BLOCK = 11'd128;
  localparam logic [10:0] LONG_BLOCK  = 11'd1024;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_HDR   = 5'b00010,
    PH_CANW  = 5'b00100,
    PH_BLOCK = 5'b01000,
    PH_FLUSH = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    PA_NONE, PA_EOT_NAK, PA_EOT_ACK, PA_CANCEL, PA_SYNC, PA_EMPTY, PA_RETRANS, PA_REJECT
  } action_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [2:0] vc;
    logic [1:0] es;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [2:0] cnt;
    res_t [3:0] r;
  } bundle_t;

  // one bit-serial crc-16/xmodem byte update, eight narrow steps
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/ymr_front.sv -----
// protocol engine: classifies each request and builds its result bundle
`default_nettype none
module ymr_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire [2:0]        cfg_idx_i,
  input  wire [15:0]       cfg_data_i,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire [1:0]        cmd_i,
  input  wire [7:0]        byte_i,
  output logic             b_valid_o,
  input  wire              b_ready_i,
  output ymr_pkg::bundle_t b_data_o
);
  import ymr_pkg::*;

  logic [15:0] hdr_w_q, byte_w_q, quiet_q;
  logic [4:0]  rlim_q;
  logic [6:0]  sync_q;

  phase_e      ph_q, ph_d;
  logic [15:0] tick_q, tick_d;
  logic [6:0]  retry_q, retry_d;
  logic [1:0]  ps_q, ps_d;
  logic        crc_q, crc_d, feot_q, feot_d, nod_q, nod_d, long_q, long_d, fdz_q, fdz_d;
  logic [7:0]  exp_q, exp_d;
  logic [4:0]  rl_q, rl_d;
  logic [10:0] pos_q, pos_d;
  logic [15:0] bnp_q, bnp_d, run_q, run_d, rcv_q, rcv_d;
  action_e     pa_q, pa_d;

  bundle_t     bun;
  logic        bv_q;
  bundle_t     bd_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_w_q <= 16'd2000; byte_w_q <= 16'd1000; quiet_q <= 16'd1500;
      rlim_q <= 5'd25; sync_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HDR:   hdr_w_q <= cfg_data_i;
        REG_BYTE:  byte_w_q <= cfg_data_i;
        REG_QUIET: quiet_q <= cfg_data_i;
        REG_RETR:  rlim_q <= cfg_data_i[4:0];
        REG_SYNC:  sync_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !bv_q || b_ready_i;
  wire acc = in_valid_i && in_ready_o;

  // next-state and result building
  always_comb begin
    logic [10:0] size, posn;
    logic [7:0]  blk, cmp, prev;
    logic        ok, abort_now, go_try, go_flush_end, go_done;
    logic [6:0]  lim7, rinc;
    logic [15:0] lim;
    logic [15:0] tk;
    action_e     a;
    ph_d = ph_q; tick_d = tick_q; retry_d = retry_q; ps_d = ps_q; crc_d = crc_q;
    feot_d = feot_q; nod_d = nod_q; long_d = long_q; fdz_d = fdz_q; exp_d = exp_q;
    rl_d = rl_q; pos_d = pos_q; bnp_d = bnp_q; run_d = run_q; rcv_d = rcv_q; pa_d = pa_q;
    bun = '0;
    go_try = 1'b0; go_flush_end = 1'b0; go_done = 1'b0;
    size = long_q ? LONG_BLOCK : SHORT_BLOCK;
    posn = pos_q + 11'd1;
    blk = 8'h00; cmp = 8'h00; prev = 8'h00; ok = 1'b0; abort_now = 1'b0;
    lim = 16'd0; tk = 16'd0; a = PA_NONE;
    lim7 = (sync_q == 7'd0) ? 7'd1 : sync_q;
    rinc = 7'd0;
    if (cmd_i == CMD_START) begin
      ps_d = PS_C; crc_d = 1'b0; exp_d = 8'd1; feot_d = 1'b1; nod_d = 1'b1;
      rl_d = rlim_q; retry_d = 7'd0; pa_d = PA_NONE; pos_d = 11'd0;
      bun.r[0] = '{K_TX, B_C, 3'd0, 2'd0, 1'b0}; bun.cnt = 3'd1;
      ph_d = PH_HDR; tick_d = 16'd0;
    end else if (cmd_i == CMD_BYTE) begin
      case (ph_q)
        PH_HDR: begin
          if (byte_i == B_SOH || byte_i == B_STX) begin
            long_d = (byte_i == B_STX);
            if (ps_q == PS_C) crc_d = 1'b1;
            ps_d = PS_NONE; pos_d = 11'd0; bnp_d = 16'd0; run_d = 16'd0;
            rcv_d = 16'd0; fdz_d = 1'b0; ph_d = PH_BLOCK; tick_d = 16'd0;
          end else if (byte_i == B_EOT) begin
            ph_d = PH_FLUSH; tick_d = 16'd0; pa_d = feot_q ? PA_EOT_NAK : PA_EOT_ACK;
          end else if (byte_i == B_CAN) begin
            ph_d = PH_CANW; tick_d = 16'd0;
          end else go_try = 1'b1;
        end
        PH_CANW: begin
          if (byte_i == B_CAN) begin
            ph_d = PH_FLUSH; tick_d = 16'd0; pa_d = PA_CANCEL;
          end else go_try = 1'b1;
        end
        PH_BLOCK: begin
          tick_d = 16'd0;
          if (pos_q == 11'd0) bnp_d = {byte_i, 8'h00};
          else if (pos_q == 11'd1) bnp_d = {bnp_q[15:8], byte_i};
          else if (pos_q < size + 11'd2) begin
            if (pos_q == 11'd2) fdz_d = (byte_i == 8'h00);
            run_d = crc_q ? crc_byte(run_q, byte_i) : {8'h00, run_q[7:0] + byte_i};
            bun.r[0] = '{K_DATA, byte_i, 3'd0, 2'd0, 1'b0}; bun.cnt = 3'd1;
          end else rcv_d = {rcv_q[7:0], byte_i};
          pos_d = posn;
          if (posn >= size + 11'd3 + {10'd0, crc_q}) go_done = 1'b1;
        end
        PH_FLUSH: tick_d = 16'd0;
        default: ;
      endcase
    end else if (cmd_i == CMD_TICK && ph_q != PH_IDLE) begin
      tk = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
      tick_d = tk;
      if (ph_q == PH_HDR) lim = hdr_w_q;
      else if (ph_q == PH_FLUSH) lim = quiet_q;
      else lim = byte_w_q;
      if (tk >= lim) begin
        tick_d = 16'd0;
        if (ph_q == PH_HDR || ph_q == PH_CANW) go_try = 1'b1;
        else if (ph_q == PH_BLOCK) begin
          bun.r[0] = '{K_VERD, {5'd0, V_REJ}, V_REJ, 2'd0, 1'b0}; bun.cnt = 3'd1;
          ph_d = PH_FLUSH; pa_d = PA_REJECT;
        end else go_flush_end = 1'b1;
      end
    end

    // block completion
    if (go_done) begin
      blk = bnp_d[15:8]; cmp = bnp_d[7:0];
      ok = crc_q ? (run_d == rcv_d) : (run_d[7:0] == rcv_d[7:0]);
      prev = exp_q - 8'd1;
      if (blk == 8'h00 && cmp == 8'hFF && ok && nod_q) begin
        if (fdz_d) begin
          bun.r[0] = '{K_VERD, {5'd0, V_EMPTY}, V_EMPTY, 2'd0, 1'b0};
          bun.r[1] = '{K_TX, B_ACK, 3'd0, 2'd0, 1'b0}; bun.cnt = 3'd2;
          ph_d = PH_FLUSH; tick_d = 16'd0; pa_d = PA_EMPTY;
        end else begin
          bun.r[0] = '{K_VERD, {5'd0, V_NAME}, V_NAME, 2'd0, 1'b0};
          bun.r[1] = '{K_TX, B_ACK, 3'd0, 2'd0, 1'b0};
          bun.r[2] = '{K_TX, B_C, 3'd0, 2'd0, 1'b0}; bun.cnt = 3'd3;
          retry_d = 7'd0; ph_d = PH_HDR; tick_d = 16'd0;
        end
      end else if (blk == ~cmp && (blk == exp_q || blk == prev) && ok) begin
        nod_d = 1'b0;
        if (blk == exp_q) begin
          bun.r[0] = '{K_VERD, {5'd0, V_KEPT}, V_KEPT, 2'd0, 1'b0};
          exp_d = exp_q + 8'd1; rl_d = rlim_q; abort_now = (rlim_q == 5'd0);
        end else begin
          bun.r[0] = '{K_VERD, {5'd0, V_DUP}, V_DUP, 2'd0, 1'b0};
          abort_now = (rl_q <= 5'd1);
          if (rl_q != 5'd0) rl_d = rl_q - 5'd1;
        end
        if (abort_now) begin
          bun.cnt = 3'd1; ph_d = PH_FLUSH; tick_d = 16'd0; pa_d = PA_RETRANS;
        end else begin
          bun.r[1] = '{K_TX, B_ACK, 3'd0, 2'd0, 1'b0}; bun.cnt = 3'd2;
          retry_d = 7'd0; ph_d = PH_HDR; tick_d = 16'd0;
        end
      end else begin
        bun.r[0] = '{K_VERD, {5'd0, V_REJ}, V_REJ, 2'd0, 1'b0}; bun.cnt = 3'd1;
        ph_d = PH_FLUSH; tick_d = 16'd0; pa_d = PA_REJECT;
      end
    end

    // end of a flush
    if (go_flush_end) begin
      a = pa_q; pa_d = PA_NONE;
      case (a)
        PA_EOT_NAK: begin
          bun.r[0] = '{K_TX, B_NAK, 3'd0, 2'd0, 1'b0}; bun.cnt = 3'd1;
          feot_d = 1'b0; go_try = 1'b1;
        end
        PA_EOT_ACK: begin
          bun.r[0] = '{K_TX, B_ACK, 3'd0, 2'd0, 1'b0};
          bun.r[1] = '{K_TX, B_C, 3'd0, 2'd0, 1'b0}; bun.cnt = 3'd2;
          feot_d = 1'b1; nod_d = 1'b1; exp_d = 8'd1; retry_d = 7'd0;
          if (ps_q == PS_C) begin
            bun.r[2] = '{K_TX, B_C, 3'd0, 2'd0, 1'b0}; bun.cnt = 3'd3;
          end else if (ps_q == PS_NAK) begin
            bun.r[2] = '{K_TX, B_NAK, 3'd0, 2'd0, 1'b0}; bun.cnt = 3'd3;
          end
          ph_d = PH_HDR; tick_d = 16'd0;
        end
        PA_CANCEL: begin
          bun.r[0] = '{K_TX, B_ACK, 3'd0, 2'd0, 1'b0};
          bun.r[1] = '{K_END, {6'd0, ES_CANCEL}, 3'd0, ES_CANCEL, 1'b0}; bun.cnt = 3'd2;
          ph_d = PH_IDLE;
        end
        PA_SYNC, PA_EMPTY, PA_RETRANS: begin
          bun.r[0] = '{K_TX, B_CAN, 3'd0, 2'd0, 1'b0};
          bun.r[1] = '{K_TX, B_CAN, 3'd0, 2'd0, 1'b0};
          bun.r[2] = '{K_TX, B_CAN, 3'd0, 2'd0, 1'b0};
          bun.r[3].kind = K_END; bun.r[3].vc = 3'd0; bun.r[3].last = 1'b0;
          bun.r[3].es = (a == PA_SYNC) ? ES_SYNC : (a == PA_EMPTY) ? ES_DONE : ES_RETRANS;
          bun.r[3].value = {6'd0, bun.r[3].es};
          bun.cnt = 3'd4; ph_d = PH_IDLE;
        end
        default: begin
          bun.r[0] = '{K_TX, B_NAK, 3'd0, 2'd0, 1'b0}; bun.cnt = 3'd1;
          retry_d = 7'd0; ph_d = PH_HDR; tick_d = 16'd0;
        end
      endcase
    end

    // next header try, appends at most one poll after the results above
    if (go_try) begin
      rinc = retry_d + 7'd1;
      retry_d = rinc;
      if (rinc < lim7 || ps_q == PS_C) begin
        if (!(rinc < lim7)) begin
          ps_d = PS_NAK; retry_d = 7'd0;
        end
        bun.r[bun.cnt[1:0]].kind = K_TX;
        bun.r[bun.cnt[1:0]].value = (ps_d == PS_C) ? B_C : B_NAK;
        if (ps_d != PS_NONE) bun.cnt = bun.cnt + 3'd1;
        ph_d = PH_HDR; tick_d = 16'd0;
      end else begin
        ph_d = PH_FLUSH; tick_d = 16'd0; pa_d = PA_SYNC;
      end
    end
    if (bun.cnt != 3'd0) bun.r[bun.cnt[1:0] - 2'd1].last = 1'b1;
  end

  // protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; tick_q <= 16'd0; retry_q <= 7'd0; ps_q <= PS_C; crc_q <= 1'b0;
      exp_q <= 8'd1; feot_q <= 1'b1; nod_q <= 1'b1; rl_q <= 5'd25; pos_q <= 11'd0;
      long_q <= 1'b0; bnp_q <= 16'd0; run_q <= 16'd0; rcv_q <= 16'd0; fdz_q <= 1'b0;
      pa_q <= PA_NONE; bv_q <= 1'b0;
    end else begin
      if (acc) begin
        ph_q <= ph_d; tick_q <= tick_d; retry_q <= retry_d; ps_q <= ps_d; crc_q <= crc_d;
        exp_q <= exp_d; feot_q <= feot_d; nod_q <= nod_d; rl_q <= rl_d; pos_q <= pos_d;
        long_q <= long_d; bnp_q <= bnp_d; run_q <= run_d; rcv_q <= rcv_d; fdz_q <= fdz_d;
        pa_q <= pa_d;
        bv_q <= (bun.cnt != 3'd0);
      end else if (b_ready_i) bv_q <= 1'b0;
    end
  end

  // bundle register
  always_ff @(posedge clk_i) begin
    if (acc) bd_q <= bun;
  end

  assign b_valid_o = bv_q;
  assign b_data_o  = bd_q;
endmodule
`default_nettype wire

// ----- rtl/core/ymr_back.sv -----
// result queue and drain: two-deep bundle queue sent out one result per handshake
`default_nettype none
module ymr_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              b_valid_i,
  output logic             b_ready_o,
  input  ymr_pkg::bundle_t b_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output ymr_pkg::res_t    out_res_o
);
  import ymr_pkg::*;

  bundle_t    q_mem [2];
  logic       wp_q, rp_q;
  logic [1:0] n_q;
  logic [1:0] idx_q;

  wire push = b_valid_i && b_ready_o;
  wire take = out_valid_o && out_ready_i;
  wire pop  = take && (idx_q == q_mem[rp_q].cnt[1:0] - 2'd1);

  assign b_ready_o   = (n_q != 2'd2);
  assign out_valid_o = (n_q != 2'd0);
  assign out_res_o   = q_mem[rp_q].r[idx_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= b_data_i;
  end

  // pointers and drain index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; n_q <= 2'd0; idx_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) begin
        rp_q <= ~rp_q; idx_q <= 2'd0;
      end else if (take) idx_q <= idx_q + 2'd1;
      n_q <= n_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/ymodem_batch_receiver.sv -----
// top level of the ymodem batch receiver
//  channel | dir | tdata                  | tuser
//  s_axis  | in  | [7:0] rx_byte          | [1:0] cmd
//  m_axis  | out | [7:0] value, [10:8] verdict_code, [12:11] end_status | kind ; tlast=last
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// one request accepted per cycle while s_axis_tready is high; it yields zero to four results,
// sent out one per cycle while m_axis_tready is high
// a two-bundle queue between engine and drain lets each side stall alone
// rst_ni clears all control state asynchronously
`default_nettype none
module ymodem_batch_receiver (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [15:0] cfg_data_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // rx_byte
  input  wire  [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // value, verdict_code, end_status
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast
);
  import ymr_pkg::*;

  logic    bv, br;
  bundle_t bd;
  res_t    r;

  ymr_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser), .byte_i(s_axis_tdata),
    .b_valid_o(bv), .b_ready_i(br), .b_data_o(bd)
  );

  ymr_back u_back (
    .clk_i, .rst_ni, .b_valid_i(bv), .b_ready_o(br), .b_data_i(bd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(r)
  );

  assign m_axis_tdata = {3'd0, r.es, r.vc, r.value};
  assign m_axis_tuser = r.kind;
  assign m_axis_tlast = r.last;
endmodule
`default_nettype wire

// ----- rtl/core/ymr_checker.sv -----
// port-level checks for the ymodem batch receiver
`default_nettype none
module ymr_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [15:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser,
  input wire        m_axis_tlast
);
  import ymr_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_vc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != K_VERD |-> m_axis_tdata[10:8] == 3'd0)
    else $error("verdict code outside verdict");
  a_es: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == K_END |-> m_axis_tlast)
    else $error("session end not last");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");
endmodule
bind ymodem_batch_receiver ymr_checker u_chk (.*);
`default_nettype wire

// ----- tb/ymodem_batch_receiver_tb.sv -----
// self-checking testbench for the ymodem batch receiver, with its own protocol predictor
`timescale 1ns / 1ps
module ymodem_batch_receiver_tb;
  import ymr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 24;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // rx_byte
  logic [1:0]  s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // value, verdict_code, end_status
  logic [1:0]  m_axis_tuser;   // kind
  logic        m_axis_tlast;

  ymodem_batch_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock, 12 ns period
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // predictor copy of the registers
  logic [15:0] hdr_wait, byte_wait, quiet_wait;
  logic [4:0]  retr_limit;
  logic [6:0]  sync_limit;

  // predictor copy of the protocol state
  phase_e      rx_phase;
  logic [15:0] tick_cnt;
  logic [6:0]  tries;
  logic [1:0]  poll_sel;
  logic        crc_on;
  logic [7:0]  next_blk;
  logic        eot_first;
  logic        fresh_batch;
  logic [4:0]  retr_left;
  logic [10:0] blk_pos;
  logic        long_blk;
  logic [15:0] num_pair;
  logic [15:0] run_chk;
  logic [15:0] got_chk;
  logic        zero_first;
  action_e     pend_act;

  // results of the request being predicted
  res_t step_res [4];
  int   step_n;

  res_t awaited_results[$];
  int   failures;
  int   send_idle_pct;
  int   take_stall_pct;
  int   idle_cycles;

  function automatic logic [15:0] crc16_step(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ 16'h1021;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function void put(input logic [1:0] k, input logic [7:0] v, input logic [2:0] vc,
                    input logic [1:0] es);
    if (step_n < 4) begin
      step_res[step_n] = '{kind: k, value: v, vc: vc, es: es, last: 1'b0};
      step_n++;
    end
  endfunction

  function void put_tx(input logic [7:0] b);
    put(K_TX, b, 3'd0, 2'd0);
  endfunction

  function void poll();
    if (poll_sel == PS_C) put_tx(B_C);
    else if (poll_sel == PS_NAK) put_tx(B_NAK);
  endfunction

  function void await_header();
    rx_phase = PH_HDR;
    tick_cnt = '0;
  endfunction

  function void begin_flush(input action_e a);
    rx_phase = PH_FLUSH;
    tick_cnt = '0;
    pend_act = a;
  endfunction

  function void close_session(input logic [1:0] st);
    put_tx(B_CAN);
    put_tx(B_CAN);
    put_tx(B_CAN);
    put(K_END, {6'd0, st}, 3'd0, st);
    rx_phase = PH_IDLE;
  endfunction

  // one more header wait, then switch to nak polling, then give up
  function void retry_sync();
    logic [6:0] lim;
    lim = (sync_limit != 0) ? sync_limit : 7'd1;
    tries = tries + 7'd1;
    if (tries < lim) begin
      poll();
      await_header();
    end else if (poll_sel == PS_C) begin
      poll_sel = PS_NAK;
      tries = '0;
      poll();
      await_header();
    end else begin
      begin_flush(PA_SYNC);
    end
  endfunction

  // line went quiet: send the reply held back during the flush
  function void flush_done();
    action_e a;
    a = pend_act;
    pend_act = PA_NONE;
    case (a)
      PA_EOT_NAK: begin
        put_tx(B_NAK);
        eot_first = 1'b0;
        retry_sync();
      end
      PA_EOT_ACK: begin
        put_tx(B_ACK);
        put_tx(B_C);
        eot_first = 1'b1;
        fresh_batch = 1'b1;
        next_blk = 8'd1;
        tries = '0;
        poll();
        await_header();
      end
      PA_CANCEL: begin
        put_tx(B_ACK);
        put(K_END, {6'd0, ES_CANCEL}, 3'd0, ES_CANCEL);
        rx_phase = PH_IDLE;
      end
      PA_SYNC:    close_session(ES_SYNC);
      PA_EMPTY:   close_session(ES_DONE);
      PA_RETRANS: close_session(ES_RETRANS);
      default: begin
        put_tx(B_NAK);
        tries = '0;
        await_header();
      end
    endcase
  endfunction

  // verdict on a complete block
  function void judge_block();
    logic [7:0] blk, cmp, prev;
    logic       ok, abort_now;
    blk = num_pair[15:8];
    cmp = num_pair[7:0];
    ok = crc_on ? (run_chk == got_chk) : (run_chk[7:0] == got_chk[7:0]);
    prev = next_blk - 8'd1;
    if (blk == 8'd0 && cmp == 8'hFF && ok && fresh_batch) begin
      if (zero_first) begin
        put(K_VERD, {5'd0, V_EMPTY}, V_EMPTY, 2'd0);
        put_tx(B_ACK);
        begin_flush(PA_EMPTY);
      end else begin
        put(K_VERD, {5'd0, V_NAME}, V_NAME, 2'd0);
        put_tx(B_ACK);
        put_tx(B_C);
        tries = '0;
        await_header();
      end
    end else if (blk == ~cmp && (blk == next_blk || blk == prev) && ok) begin
      fresh_batch = 1'b0;
      if (blk == next_blk) begin
        put(K_VERD, {5'd0, V_KEPT}, V_KEPT, 2'd0);
        next_blk = next_blk + 8'd1;
        retr_left = retr_limit;
        abort_now = (retr_left == 0);
      end else begin
        put(K_VERD, {5'd0, V_DUP}, V_DUP, 2'd0);
        abort_now = (retr_left <= 1);
        if (retr_left != 0) retr_left = retr_left - 5'd1;
      end
      if (abort_now) begin
        begin_flush(PA_RETRANS);
      end else begin
        put_tx(B_ACK);
        tries = '0;
        await_header();
      end
    end else begin
      put(K_VERD, {5'd0, V_REJ}, V_REJ, 2'd0);
      begin_flush(PA_REJECT);
    end
  endfunction

  function void take_block_byte(input logic [7:0] b);
    int sz, p;
    sz = long_blk ? 1024 : 128;
    p = blk_pos;
    tick_cnt = '0;
    if (p == 0) begin
      num_pair = {b, 8'h00};
    end else if (p == 1) begin
      num_pair[7:0] = b;
    end else if (p < sz + 2) begin
      if (p == 2) zero_first = (b == 8'd0);
      if (crc_on) run_chk = crc16_step(run_chk, b);
      else run_chk = {8'h00, run_chk[7:0] + b};
      put(K_DATA, b, 3'd0, 2'd0);
    end else begin
      got_chk = {got_chk[7:0], b};
    end
    p++;
    blk_pos = p[10:0];
    if (p >= sz + 3 + int'(crc_on)) judge_block();
  endfunction

  function void take_header(input logic [7:0] b);
    if (b == B_SOH || b == B_STX) begin
      long_blk = (b == B_STX);
      if (poll_sel == PS_C) crc_on = 1'b1;
      poll_sel = PS_NONE;
      blk_pos = '0;
      num_pair = '0;
      run_chk = '0;
      got_chk = '0;
      zero_first = 1'b0;
      rx_phase = PH_BLOCK;
      tick_cnt = '0;
    end else if (b == B_EOT) begin
      begin_flush(eot_first ? PA_EOT_NAK : PA_EOT_ACK);
    end else if (b == B_CAN) begin
      rx_phase = PH_CANW;
      tick_cnt = '0;
    end else begin
      retry_sync();
    end
  endfunction

  // results caused by one request, left in step_res
  function void predict_receiver(input logic [1:0] cmd, input logic [7:0] b);
    logic [15:0] lim;
    step_n = 0;
    if (cmd == CMD_START) begin
      poll_sel = PS_C;
      crc_on = 1'b0;
      next_blk = 8'd1;
      eot_first = 1'b1;
      fresh_batch = 1'b1;
      retr_left = retr_limit;
      tries = '0;
      pend_act = PA_NONE;
      blk_pos = '0;
      poll();
      await_header();
    end else if (cmd == CMD_BYTE) begin
      case (rx_phase)
        PH_HDR:  take_header(b);
        PH_CANW: begin
          if (b == B_CAN) begin_flush(PA_CANCEL);
          else retry_sync();
        end
        PH_BLOCK: take_block_byte(b);
        PH_FLUSH: tick_cnt = '0;
        default: ;
      endcase
    end else if (cmd == CMD_TICK && rx_phase != PH_IDLE) begin
      if (tick_cnt != 16'hFFFF) tick_cnt = tick_cnt + 16'd1;
      if (rx_phase == PH_HDR) lim = hdr_wait;
      else if (rx_phase == PH_FLUSH) lim = quiet_wait;
      else lim = byte_wait;
      if (tick_cnt >= lim) begin
        tick_cnt = '0;
        if (rx_phase == PH_HDR || rx_phase == PH_CANW) begin
          retry_sync();
        end else if (rx_phase == PH_BLOCK) begin
          put(K_VERD, {5'd0, V_REJ}, V_REJ, 2'd0);
          begin_flush(PA_REJECT);
        end else begin
          flush_done();
        end
      end
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endfunction

  // one request to the block; typed_n < 0 means the predictor gives the results
  task automatic send_req(input logic [1:0] cmd, input logic [7:0] b, input int typed_n = -1,
                          input logic [1:0] k = K_TX, input logic [7:0] v = 8'd0);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_receiver(cmd, b);
    if (typed_n < 0) begin
      for (int i = 0; i < step_n; i++) awaited_results.push_back(step_res[i]);
    end else if (typed_n > 0) begin
      awaited_results.push_back('{kind: k, value: v,
                                  vc: (k == K_VERD) ? v[2:0] : 3'd0,
                                  es: (k == K_END) ? v[1:0] : 2'd0, last: 1'b1});
    end
  endtask

  // sender quiet until every awaited result is out, then a margin for silent work
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_HDR:   hdr_wait = val;
      REG_BYTE:  byte_wait = val;
      REG_QUIET: quiet_wait = val;
      REG_RETR:  retr_limit = val[4:0];
      REG_SYNC:  sync_limit = val[6:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] hw, input logic [15:0] bw, input logic [15:0] qw,
                           input logic [15:0] rl, input logic [15:0] sl);
    write_reg(REG_HDR, hw);
    write_reg(REG_BYTE, bw);
    write_reg(REG_QUIET, qw);
    write_reg(REG_RETR, rl);
    write_reg(REG_SYNC, sl);
  endtask

  // full short block, given first byte then random payload; mode follows the predicted checksum mode
  task automatic send_block(input logic [7:0] num, input logic [7:0] first, input bit spoil);
    logic [15:0] chk;
    logic [7:0]  d;
    send_req(CMD_BYTE, B_SOH);
    send_req(CMD_BYTE, num);
    send_req(CMD_BYTE, ~num);
    chk = '0;
    for (int i = 0; i < 128; i++) begin
      d = (i == 0) ? first : 8'($urandom_range(0, 255));
      if (crc_on) chk = crc16_step(chk, d);
      else chk = {8'h00, chk[7:0] + d};
      send_req(CMD_BYTE, d);
    end
    if (spoil) chk = chk ^ 16'h0001;
    if (crc_on) send_req(CMD_BYTE, chk[15:8]);
    send_req(CMD_BYTE, chk[7:0]);
  endtask

  // a block cut short, followed by two ticks for the byte timer and the quiet timer
  task automatic broken_block();
    int n;
    n = $urandom_range(0, 6);
    send_req(CMD_BYTE, $urandom_range(0, 1) ? B_STX : B_SOH);
    for (int i = 0; i < n; i++) send_req(CMD_BYTE, 8'($urandom_range(0, 255)));
    send_req(CMD_TICK, 8'($urandom_range(0, 255)));
    send_req(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  // random line traffic biased towards protocol bytes
  task automatic line_noise(input int n);
    int r;
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
        0: b = B_SOH;
        1: b = B_STX;
        2: b = B_EOT;
        3, 4: b = B_CAN;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (r < 45) send_req(CMD_BYTE, b);
      else if (r < 85) send_req(CMD_TICK, 8'($urandom_range(0, 255)));
      else if (r < 95) send_req(CMD_START, 8'($urandom_range(0, 255)));
      else send_req(2'd3, 8'($urandom_range(0, 255)));
    end
  endtask

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] b;
    int         typed_n;
    logic [1:0] k;
    logic [7:0] v;
  } stim_row_t;

  // directed sequence, run with every timer at one tick and one sync try
  stim_row_t directed [25] = '{
    '{CMD_BYTE,  8'h00, 0,  K_TX,   8'h00},  // idle ignores bytes
    '{CMD_TICK,  8'hFF, 0,  K_TX,   8'h00},  // and ticks
    '{2'd3,      8'hA5, 0,  K_TX,   8'h00},  // unknown command
    '{CMD_START, 8'h00, 1,  K_TX,   B_C},
    '{CMD_TICK,  8'h00, 1,  K_TX,   B_NAK},  // sync tries spent, nak polling
    '{CMD_BYTE,  8'h55, 0,  K_TX,   8'h00},  // junk header, sync flush
    '{CMD_BYTE,  8'hFF, 0,  K_TX,   8'h00},
    '{CMD_TICK,  8'h00, -1, K_TX,   8'h00},  // sync error end
    '{CMD_START, 8'h00, 1,  K_TX,   B_C},
    '{CMD_BYTE,  B_CAN, 0,  K_TX,   8'h00},
    '{CMD_BYTE,  B_CAN, 0,  K_TX,   8'h00},  // cancel pair
    '{CMD_TICK,  8'h00, -1, K_TX,   8'h00},
    '{CMD_START, 8'h00, 1,  K_TX,   B_C},
    '{CMD_BYTE,  B_CAN, 0,  K_TX,   8'h00},
    '{CMD_TICK,  8'h00, 1,  K_TX,   B_NAK},  // lone cancel times out
    '{CMD_BYTE,  B_EOT, 0,  K_TX,   8'h00},  // first eot
    '{CMD_TICK,  8'h00, -1, K_TX,   8'h00},
    '{CMD_BYTE,  B_EOT, -1, K_TX,   8'h00},  // second eot
    '{CMD_TICK,  8'h00, -1, K_TX,   8'h00},
    '{CMD_BYTE,  8'hFF, -1, K_TX,   8'h00},
    '{CMD_START, 8'h00, 1,  K_TX,   B_C},
    '{CMD_BYTE,  B_SOH, 0,  K_TX,   8'h00},
    '{CMD_TICK,  8'h00, 1,  K_VERD, 8'd3},   // timeout inside a block
    '{CMD_TICK,  8'h00, 1,  K_TX,   B_NAK},
    '{CMD_START, 8'hFF, 1,  K_TX,   B_C}
  };

  // result checker
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        $error("result with none awaited: kind %0d value %0h", m_axis_tuser, m_axis_tdata[7:0]);
        failures++;
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          failures++;
        end
        if (m_axis_tdata[7:0] !== want.value) begin
          $error("value: expected %0h, got %0h", want.value, m_axis_tdata[7:0]);
          failures++;
        end
        if (m_axis_tdata[10:8] !== want.vc) begin
          $error("verdict_code: expected %0d, got %0d", want.vc, m_axis_tdata[10:8]);
          failures++;
        end
        if (m_axis_tdata[12:11] !== want.es) begin
          $error("end_status: expected %0d, got %0d", want.es, m_axis_tdata[12:11]);
          failures++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          failures++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= take_stall_pct);
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b1;
    failures = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    take_stall_pct = 0;
    // reset values of the predictor
    hdr_wait = 16'd2000;
    byte_wait = 16'd1000;
    quiet_wait = 16'd1500;
    retr_limit = 5'd25;
    sync_limit = 7'd64;
    rx_phase = PH_IDLE;
    tick_cnt = '0;
    tries = '0;
    poll_sel = PS_C;
    crc_on = 1'b0;
    next_blk = 8'd1;
    eot_first = 1'b1;
    fresh_batch = 1'b1;
    retr_left = 5'd25;
    blk_pos = '0;
    long_blk = 1'b0;
    num_pair = '0;
    run_chk = '0;
    got_chk = '0;
    zero_first = 1'b0;
    pend_act = PA_NONE;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    write_all(16'd1, 16'd1, 16'd1, 16'd2, 16'd1);
    foreach (directed[i]) begin
      send_req(directed[i].cmd, directed[i].b, directed[i].typed_n, directed[i].k,
               directed[i].v);
    end
    settle();

    // kept block, then a duplicate that spends the retransmit budget
    write_all(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd127);
    send_req(CMD_START, 8'($urandom_range(0, 255)));
    send_block(8'd1, 8'($urandom_range(0, 255)), 1'b0);
    send_block(8'd1, 8'($urandom_range(0, 255)), 1'b0);
    send_req(CMD_TICK, 8'd0);
    settle();

    // checksum mode and the empty batch end, sender idling
    send_idle_pct = 70;
    write_all(16'd1, 16'd2, 16'hFFFF, 16'd31, 16'd0);
    send_req(CMD_START, 8'($urandom_range(0, 255)));
    send_req(CMD_TICK, 8'($urandom_range(0, 255)));
    send_block(8'd0, 8'd0, 1'b0);
    settle();

    // broken block and noise, receiver stalling
    send_idle_pct = 0;
    take_stall_pct = 70;
    write_all(16'd0, 16'd0, 16'd1, 16'd0, 16'd3);
    send_req(CMD_START, 8'($urandom_range(0, 255)));
    broken_block();
    line_noise(6);
    settle();

    // both sides idling
    send_idle_pct = 36;
    take_stall_pct = 36;
    write_all(16'd2, 16'd3, 16'd2, 16'd5, 16'd2);
    send_req(CMD_START, 8'($urandom_range(0, 255)));
    broken_block();
    line_noise(6);
    settle();

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
